>>> hw/rtl/llh_pkg.sv
// shared types and constants for the latency log2 histogram
`default_nettype none
package llh_pkg;
  localparam logic [1:0] ACT_ENTRY = 2'd0;
  localparam logic [1:0] ACT_RETURN = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_ENTRY = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_BIN_RANGE = 2'd3;

  localparam int unsigned NS_PER_US = 1000;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] thread_id;
    logic [63:0] time_ns;
    logic [5:0]  read_bin;
  } item_t;
endpackage
`default_nettype wire

>>> hw/rtl/llh_fifo.sv
// two-entry queue between the front and back parts
`default_nettype none
module llh_fifo import llh_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  item_t data_i,
  output logic  full_o,
  input  wire   pop_i,
  output logic  empty_o,
  output item_t data_o
);
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/llh_back.sv
// table search, latency binning and histogram update
`default_nettype none
module llh_back import llh_pkg::*; #(
  parameter int unsigned TableEntries = 1024,
  parameter int unsigned BinCount = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         q_empty_i,
  input  item_t       q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  status_o,
  output logic [6:0]  bin_o,
  output logic [63:0] count_o
);
  localparam int unsigned IW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CW = $clog2(TableEntries + 2);
  localparam int unsigned ClrN = (TableEntries > BinCount) ? TableEntries : BinCount;
  localparam int unsigned LW = $clog2(ClrN);

  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_SCAN = 4'd2, S_RD = 4'd3,
                         S_DELTA = 4'd4, S_LOG = 4'd5, S_HRD = 4'd6, S_HWR = 4'd7,
                         S_OUT = 4'd8, S_WR = 4'd9;

  logic [3:0]    st_q;
  item_t         it_q;
  logic [CW-1:0] idx_q;
  logic          found_q, free_ok_q;
  logic [IW-1:0] hit_q, free_q;
  logic [63:0]   val_q;
  logic [64:0]   thr_q;
  logic [6:0]    bin_q;
  logic [63:0]   cnt_q;
  logic [1:0]    stat_q;
  logic          ov_q;
  logic [1:0]    out_stat_q;
  logic [6:0]    out_bin_q;
  logic [63:0]   out_cnt_q;
  logic [LW-1:0] clr_q;
  logic          out_load;

  logic [32:0]   ent_mem [TableEntries];
  logic [63:0]   time_mem [TableEntries];
  logic [63:0]   hist_mem [BinCount];
  logic [32:0]   ent_rd;
  logic [63:0]   time_rd, hist_rd;

  logic [IW-1:0] idx_w, prev_w, wr_idx;
  assign idx_w = idx_q[IW-1:0];
  assign prev_w = IW'(idx_q - CW'(1));
  assign wr_idx = found_q ? hit_q : free_q;

  // table word: valid bit on top of the thread id
  always_ff @(posedge clk_i) begin
    ent_rd <= ent_mem[idx_w];
    time_rd <= time_mem[hit_q];
    hist_rd <= hist_mem[bin_q[5:0]];
    if (st_q == S_CLR) begin
      if (32'(clr_q) < TableEntries) ent_mem[clr_q[IW-1:0]] <= '0;
    end else if (st_q == S_WR) begin
      ent_mem[wr_idx] <= {1'b1, it_q.thread_id};
    end else if (st_q == S_RD && it_q.action != ACT_READ) begin
      ent_mem[hit_q] <= {1'b0, it_q.thread_id};
    end
    if (st_q == S_WR) time_mem[wr_idx] <= it_q.time_ns;
    if (st_q == S_CLR) begin
      if (32'(clr_q) < BinCount) hist_mem[clr_q[5:0]] <= 64'd0;
    end else if (st_q == S_HWR) hist_mem[bin_q[5:0]] <= hist_rd + 64'd1;
  end

  assign q_pop_o = (st_q == S_IDLE) && !q_empty_i;
  assign out_load = (st_q == S_OUT) && (!ov_q || !out_stall_i);
  assign out_valid_o = ov_q;
  assign status_o = out_stat_q;
  assign bin_o = out_bin_q;
  assign count_o = out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR;
      clr_q <= '0;
      ov_q <= 1'b0;
      out_stat_q <= ST_OK;
      out_bin_q <= 7'd0;
      out_cnt_q <= 64'd0;
      it_q <= '0;
      idx_q <= '0;
      found_q <= 1'b0;
      free_ok_q <= 1'b0;
      hit_q <= '0;
      free_q <= '0;
      val_q <= 64'd0;
      thr_q <= 65'd0;
      bin_q <= 7'd0;
      cnt_q <= 64'd0;
      stat_q <= ST_OK;
    end else begin
      if (out_load) begin
        ov_q <= 1'b1;
        out_stat_q <= stat_q;
        out_bin_q <= bin_q;
        out_cnt_q <= cnt_q;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        S_CLR: begin
          clr_q <= clr_q + LW'(1);
          if (clr_q == LW'(ClrN - 1)) st_q <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty_i) begin
            it_q <= q_data_i;
            idx_q <= '0;
            found_q <= 1'b0;
            free_ok_q <= 1'b0;
            stat_q <= ST_OK;
            bin_q <= 7'd0;
            cnt_q <= 64'd0;
            case (q_data_i.action)
              ACT_ENTRY, ACT_RETURN: st_q <= S_SCAN;
              ACT_READ: begin
                bin_q <= {1'b0, q_data_i.read_bin};
                if (32'(q_data_i.read_bin) >= BinCount) begin
                  stat_q <= ST_BIN_RANGE;
                  st_q <= S_OUT;
                end else st_q <= S_RD;
              end
              default: st_q <= S_OUT;
            endcase
          end
        end
        S_SCAN: begin
          if (idx_q <= CW'(TableEntries)) idx_q <= idx_q + CW'(1);
          if (idx_q != '0 && idx_q <= CW'(TableEntries)) begin
            if (!ent_rd[32] && !free_ok_q) begin
              free_ok_q <= 1'b1;
              free_q <= prev_w;
            end
            if (ent_rd[32] && ent_rd[31:0] == it_q.thread_id && !found_q) begin
              found_q <= 1'b1;
              hit_q <= prev_w;
            end
          end
          if (idx_q == CW'(TableEntries + 1)) begin
            if (it_q.action == ACT_ENTRY) begin
              if (found_q || free_ok_q) st_q <= S_WR;
              else begin
                stat_q <= ST_TABLE_FULL;
                st_q <= S_OUT;
              end
            end else if (found_q) st_q <= S_RD;
            else begin
              stat_q <= ST_NO_ENTRY;
              st_q <= S_OUT;
            end
          end
        end
        S_WR: begin
          st_q <= S_OUT;
        end
        S_RD: begin
          if (it_q.action == ACT_READ) st_q <= S_HRD;
          else st_q <= S_DELTA;
        end
        S_DELTA: begin
          val_q <= it_q.time_ns - time_rd;
          thr_q <= 65'(NS_PER_US) << 1;
          bin_q <= 7'd1;
          st_q <= S_LOG;
        end
        // bin grows while the difference reaches 1000 ns times the next power of two
        S_LOG: begin
          if ({1'b0, val_q} >= thr_q) begin
            thr_q <= thr_q << 1;
            bin_q <= bin_q + 7'd1;
          end else if (32'(bin_q) >= BinCount) begin
            stat_q <= ST_BIN_RANGE;
            st_q <= S_OUT;
          end else st_q <= S_HRD;
        end
        S_HRD: begin
          if (it_q.action == ACT_READ) begin
            cnt_q <= hist_rd;
            st_q <= S_OUT;
          end else st_q <= S_HWR;
        end
        S_HWR: begin
          cnt_q <= hist_rd + 64'd1;
          st_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  ap_out_only_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(st_q) == S_OUT) else $error("result without finish");
  ap_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> st_q == S_IDLE) else $error("pop while busy");
  ap_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable({out_stat_q, out_bin_q, out_cnt_q}))
    else $error("result lost");
endmodule
`default_nettype wire

>>> hw/rtl/latency_log2_histogram.sv
// top level of the latency log2 histogram
// usage: events enter on in_valid_i/in_stall_o with action, thread id, time and bin.
// the front part registers each beat into a two-entry queue; the back part takes one
// event at a time and returns exactly one result beat per event on out_valid_o.
// an event is popped in the cycle after its input beat when the back part is idle;
// the next event is popped in the cycle after the previous result beat is loaded.
// an entry event scans the id table one slot per cycle, then takes its own or a free slot.
// a return event scans the table, then compares the time difference against
// 2000 ns doubled once per cycle to find its bin, then updates that bin's count.
// a bin read fetches that bin's count; an unused action goes straight to its result.
// after reset the back part clears the table valid bits and the histogram over the
// larger of TableEntries and BinCount slots; events are queued meanwhile.
// when the receiver holds out_stall_i the result beat holds steady; the back part
// may finish one more event and then waits; the queue fills and in_stall_o rises.
`default_nettype none
module latency_log2_histogram import llh_pkg::*; #(
  parameter int unsigned TableEntries = 1024,
  parameter int unsigned BinCount = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  action_i,
  input  wire  [31:0] thread_id_i,
  input  wire  [63:0] time_ns_i,
  input  wire  [5:0]  read_bin_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  status_o,
  output logic [6:0]  bin_o,
  output logic [63:0] count_o
);
  item_t in_item, q_item;
  logic  q_full, q_empty, q_pop, push;

  assign in_item = '{action: action_i, thread_id: thread_id_i,
                     time_ns: time_ns_i, read_bin: read_bin_i};
  assign in_stall_o = q_full;
  assign push = in_valid_i && !q_full;

  llh_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_item), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_item)
  );

  llh_back #(.TableEntries(TableEntries), .BinCount(BinCount)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .status_o, .bin_o, .count_o
  );
endmodule
`default_nettype wire

>>> tb/tb_latency_log2_histogram.sv
// testbench for the latency log2 histogram: directed table, random traffic, table fill
`timescale 1ns / 1ps
module tb_latency_log2_histogram import llh_pkg::*; ();

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned BIN_COUNT = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned MAX_GAP = 12;
  localparam int unsigned DRAIN_CYCLES = 1400;
  localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  bin;
    logic [63:0] count;
  } result_t;

  typedef struct {
    item_t   ev;
    bit      typed;
    result_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [31:0] thread_id_i = '0;
  logic [63:0] time_ns_i = '0;
  logic [5:0]  read_bin_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [6:0]  bin_o;
  logic [63:0] count_o;

  logic [31:0] tab_id [TABLE_ENTRIES];
  bit          tab_live [TABLE_ENTRIES];
  logic [63:0] tab_start [TABLE_ENTRIES];
  logic [63:0] hist [BIN_COUNT];

  result_t     pending_q [$];
  int          fails = 0;
  bit          quiet = 1'b0;
  longint unsigned cycles = 0;
  logic [31:0] id_pool [16];
  int          full_drops = 0;

  latency_log2_histogram i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .thread_id_i, .time_ns_i,
    .read_bin_i, .out_valid_o, .out_stall_i, .status_o, .bin_o, .count_o
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int find_id(logic [31:0] id);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tab_live[i] && tab_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (!tab_live[i]) return i;
    return -1;
  endfunction

  function automatic logic [6:0] log2_bin(logic [63:0] v);
    logic [6:0] b;
    b = 7'd1;
    while (v > 64'd1) begin
      v = v >> 1;
      b++;
    end
    return b;
  endfunction

  task automatic predict_latency(input item_t ev, output result_t r);
    int slot;
    logic [6:0] b;
    r = '0;
    case (ev.action)
      ACT_ENTRY: begin
        slot = find_id(ev.thread_id);
        if (slot < 0) slot = find_free();
        if (slot < 0) begin
          r.status = ST_TABLE_FULL;
          full_drops++;
        end else begin
          tab_id[slot] = ev.thread_id;
          tab_start[slot] = ev.time_ns;
          tab_live[slot] = 1'b1;
        end
      end
      ACT_RETURN: begin
        slot = find_id(ev.thread_id);
        if (slot < 0) begin
          r.status = ST_NO_ENTRY;
        end else begin
          b = log2_bin((ev.time_ns - tab_start[slot]) / NS_PER_US);
          r.bin = b;
          if (b >= BIN_COUNT) begin
            r.status = ST_BIN_RANGE;
          end else begin
            hist[b] = hist[b] + 64'd1;
            r.count = hist[b];
          end
          tab_live[slot] = 1'b0;
        end
      end
      ACT_READ: begin
        r.bin = {1'b0, ev.read_bin};
        if (ev.read_bin >= BIN_COUNT) r.status = ST_BIN_RANGE;
        else r.count = hist[ev.read_bin];
      end
      default: ;
    endcase
  endtask

  task automatic send_event(input item_t ev, input bit typed, input result_t res);
    int gap;
    result_t r;
    gap = quiet ? 0 : int'($urandom_range(0, MAX_GAP));
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i = ev.action;
    thread_id_i = ev.thread_id;
    time_ns_i = ev.time_ns;
    read_bin_i = ev.read_bin;
    do @(posedge clk_i); while (in_stall_o);
    predict_latency(ev, r);
    pending_q.push_back(typed ? res : r);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t mixed_event();
    item_t ev;
    int slot;
    ev.action = $urandom_range(0, 9) < 4 ? ACT_ENTRY :
                ($urandom_range(0, 5) < 4 ? ACT_RETURN :
                ($urandom_range(0, 5) == 0 ? ACT_UNUSED : ACT_READ));
    ev.thread_id = id_pool[$urandom_range(0, 15)];
    ev.time_ns = rand64();
    ev.read_bin = 6'($urandom_range(0, 63));
    if (ev.action == ACT_RETURN && $urandom_range(0, 5) != 0) begin
      slot = find_id(ev.thread_id);
      if (slot >= 0)
        ev.time_ns = tab_start[slot] + (rand64() >> $urandom_range(0, 63));
    end
    return ev;
  endfunction

  initial begin
    row_t rows [$];
    item_t ev;
    result_t none;
    int slot;
    none = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) tab_live[i] = 1'b0;
    for (int i = 0; i < BIN_COUNT; i++) hist[i] = '0;
    for (int i = 0; i < 16; i++) id_pool[i] = $urandom;

    rows.push_back('{'{ACT_READ, 32'd0, 64'd0, 6'd0}, 1'b1, '{ST_OK, 7'd0, 64'd0}});
    rows.push_back('{'{ACT_READ, 32'd0, 64'd0, 6'd63}, 1'b1, '{ST_OK, 7'd63, 64'd0}});
    rows.push_back('{'{ACT_RETURN, 32'd7, 64'd0, 6'd0}, 1'b1, '{ST_NO_ENTRY, 7'd0, 64'd0}});
    rows.push_back('{'{ACT_ENTRY, 32'd0, 64'd0, 6'd0}, 1'b1, '{ST_OK, 7'd0, 64'd0}});
    rows.push_back('{'{ACT_RETURN, 32'd0, 64'd0, 6'd0}, 1'b1, '{ST_OK, 7'd1, 64'd1}});
    rows.push_back('{'{ACT_RETURN, 32'd0, 64'd0, 6'd0}, 1'b1, '{ST_NO_ENTRY, 7'd0, 64'd0}});
    rows.push_back('{'{ACT_ENTRY, 32'hFFFF_FFFF, '1, 6'd0}, 1'b1, '{ST_OK, 7'd0, 64'd0}});
    rows.push_back('{'{ACT_RETURN, 32'hFFFF_FFFF, 64'd0, 6'd0}, 1'b0, none});
    rows.push_back('{'{ACT_ENTRY, 32'd5, 64'd100, 6'd0}, 1'b0, none});
    rows.push_back('{'{ACT_ENTRY, 32'd5, 64'd2000, 6'd0}, 1'b0, none});
    rows.push_back('{'{ACT_RETURN, 32'd5, 64'd3999, 6'd0}, 1'b0, none});
    rows.push_back('{'{ACT_ENTRY, 32'd9, 64'd0, 6'd0}, 1'b0, none});
    rows.push_back('{'{ACT_RETURN, 32'd9, '1, 6'd0}, 1'b0, none});
    rows.push_back('{'{ACT_ENTRY, 32'd10, 64'd50, 6'd0}, 1'b0, none});
    rows.push_back('{'{ACT_RETURN, 32'd10, 64'd8050, 6'd0}, 1'b0, none});
    rows.push_back('{'{ACT_UNUSED, 32'hFFFF_FFFF, '1, 6'd63}, 1'b1, '{ST_OK, 7'd0, 64'd0}});
    rows.push_back('{'{ACT_READ, 32'd0, 64'd0, 6'd1}, 1'b0, none});
    rows.push_back('{'{ACT_READ, 32'd0, 64'd0, 6'd4}, 1'b0, none});
    rows.push_back('{'{ACT_READ, 32'd0, 64'd0, 6'd55}, 1'b0, none});

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].res);

    for (int n = 0; n < 40; n++) begin
      if (n % 10 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (n == 20) begin
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk_i);
      end
      send_event(mixed_event(), 1'b0, none);
    end
    quiet = 1'b0;

    while (full_drops < 6) begin
      ev.action = ACT_ENTRY;
      ev.thread_id = $urandom;
      ev.time_ns = rand64();
      ev.read_bin = 6'($urandom_range(0, 63));
      send_event(ev, 1'b0, none);
    end

    for (int n = 0; n < 15; n++) begin
      ev = mixed_event();
      if (ev.action == ACT_RETURN) begin
        slot = $urandom_range(0, TABLE_ENTRIES - 1);
        if (tab_live[slot]) begin
          ev.thread_id = tab_id[slot];
          ev.time_ns = tab_start[slot] + (rand64() >> $urandom_range(0, 63));
        end
      end
      send_event(ev, 1'b0, none);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    result_t want;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          want = pending_q.pop_front();
          if (status_o !== want.status) begin
            $error("status expected %0d got %0d", want.status, status_o);
            fails++;
          end
          if (bin_o !== want.bin) begin
            $error("bin expected %0d got %0d", want.bin, bin_o);
            fails++;
          end
          if (count_o !== want.count) begin
            $error("count expected %0d got %0d", want.count, count_o);
            fails++;
          end
        end
        hold = quiet ? 0 : int'($urandom_range(0, MAX_GAP));
      end
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        hold--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end
endmodule

>>> latency_log2_histogram.f
hw/rtl/llh_pkg.sv
hw/rtl/llh_fifo.sv
hw/rtl/llh_back.sv
hw/rtl/latency_log2_histogram.sv
tb/tb_latency_log2_histogram.sv
